// ===== hw/rtl/asd_pkg.sv =====
// ----------------------------------------------------------------------------
// asd_pkg
// Shared types, codes and default constants of the arithmetic symbol decoder.
// ----------------------------------------------------------------------------
package asd_pkg;

  // Default configuration of the decoder.
  localparam int CODE_BITS_DEF   = 16;
  localparam int NUM_SYMBOLS_DEF = 257;
  localparam int FREQ_BITS_DEF   = 14;
  localparam int QUEUE_BITS_DEF  = 64;
  localparam int BYTE_BITS       = 8;

  // Request codes.
  typedef enum logic [1:0] {
    REQ_LOAD    = 2'd0,
    REQ_RESTART = 2'd1,
    REQ_APPEND  = 2'd2,
    REQ_DECODE  = 2'd3
  } req_e_t;

  // Status codes.
  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_UFL = 2'd1;
  localparam logic [1:0] ST_OVF = 2'd2;

  // Input transaction.
  typedef struct packed {
    logic [1:0]  req_type;
    logic [8:0]  table_index;
    logic [13:0] table_value;
    logic [7:0]  data_byte;
  } in_t;

  // Result transaction.
  typedef struct packed {
    logic [8:0] symbol;
    logic       symbol_valid;
    logic [1:0] status;
    logic [6:0] bits_queued;
  } out_t;

  // Classified command handed from the front end to the back end.
  typedef struct packed {
    req_e_t      op;
    logic        idx_ok;
    logic [8:0]  table_index;
    logic [13:0] table_value;
    logic [7:0]  data_byte;
  } cmd_t;

  // Back-end sequencer states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_HDR,
    S_TOT_RD,
    S_TOT_CHK,
    S_MUL_CUM,
    S_DIV_CUM,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_MUL_HI,
    S_DIV_HI,
    S_MUL_LO,
    S_DIV_LO,
    S_RENORM,
    S_DONE
  } state_t;

endpackage

// ===== hw/rtl/asd_front.sv =====
// ----------------------------------------------------------------------------
// asd_front
// Accepts input transactions, classifies them and holds them in a two-entry
// queue for the back end.
// ----------------------------------------------------------------------------
module asd_front #(
  parameter int NUM_SYMBOLS = asd_pkg::NUM_SYMBOLS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  asd_pkg::in_t  in_data,
  output logic          cmd_valid,
  input  logic          cmd_pop,
  output asd_pkg::cmd_t cmd
);
  import asd_pkg::*;

  cmd_t       slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push;
  logic       pop;
  cmd_t       cls;

  // Classify the incoming transaction.
  always_comb begin
    cls.op          = req_e_t'(in_data.req_type);
    cls.idx_ok      = (32'(in_data.table_index) <= NUM_SYMBOLS);
    cls.table_index = in_data.table_index;
    cls.table_value = in_data.table_value;
    cls.data_byte   = in_data.data_byte;
  end

  assign in_stall  = (cnt_r == 2'd2);
  assign push      = in_valid && !in_stall;
  assign cmd_valid = (cnt_r != 2'd0);
  assign pop       = cmd_pop && cmd_valid;
  assign cmd       = slot_r[rd_ptr_r];

  // Queue pointers and fill level.
  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= cls;
    end
  end

endmodule

// ===== hw/rtl/asd_div.sv =====
// ----------------------------------------------------------------------------
// asd_div
// Restoring divider that produces one quotient bit per cycle.
// ----------------------------------------------------------------------------
module asd_div #(
  parameter int DW = 31,
  parameter int VW = 17
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          done,
  output logic [DW-1:0] quotient
);
  import asd_pkg::*;

  localparam int CW = $clog2(DW + 1);

  logic [VW-1:0] rem_r, rem_nxt;
  logic [DW-1:0] quo_r, quo_nxt;
  logic [VW-1:0] dvs_r, dvs_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [VW:0]   trial;

  assign trial    = {rem_r, quo_r[DW-1]};
  assign done     = done_r;
  assign quotient = quo_r;

  // One shift-and-subtract step per cycle.
  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = '0;
      quo_nxt  = dividend;
      dvs_nxt  = divisor;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = VW'(trial - {1'b0, dvs_r});
        quo_nxt = {quo_r[DW-2:0], 1'b1};
      end else begin
        rem_nxt = trial[VW-1:0];
        quo_nxt = {quo_r[DW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CW'(DW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
    cnt_r <= cnt_nxt;
  end

endmodule

// ===== hw/rtl/asd_core.sv =====
// ----------------------------------------------------------------------------
// asd_core
// Back end: frequency table memory, bit queue, interval state, the decode
// sequencer and the result register.
// ----------------------------------------------------------------------------
module asd_core #(
  parameter int CODE_BITS   = asd_pkg::CODE_BITS_DEF,
  parameter int NUM_SYMBOLS = asd_pkg::NUM_SYMBOLS_DEF,
  parameter int FREQ_BITS   = asd_pkg::FREQ_BITS_DEF,
  parameter int QUEUE_BITS  = asd_pkg::QUEUE_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cmd_valid,
  output logic          cmd_pop,
  input  asd_pkg::cmd_t cmd,
  output logic          out_valid,
  input  logic          out_stall,
  output asd_pkg::out_t out_data
);
  import asd_pkg::*;

  localparam int CB    = CODE_BITS;
  localparam int FB    = FREQ_BITS;
  localparam int DEPTH = NUM_SYMBOLS + 1;
  localparam int SW    = $clog2(DEPTH);
  localparam int DW    = CB + FB + 1;
  localparam int VW    = CB + 1;
  localparam int QCW   = $clog2(QUEUE_BITS + 1);
  localparam int NW    = $clog2(CB + 1);
  localparam logic [CB-1:0] HALF = CB'(1) << (CB - 1);
  localparam logic [CB-1:0] QTR1 = CB'(1) << (CB - 2);
  localparam logic [CB-1:0] QTR3 = HALF | QTR1;

  // Frequency table memory.
  logic [FB-1:0] mem [DEPTH];
  logic [FB-1:0] rdata_r;
  logic          mem_we;

  state_t            state_r, state_nxt;
  logic [CB-1:0]     low_r, low_nxt;
  logic [CB-1:0]     high_r, high_nxt;
  logic [CB-1:0]     code_r, code_nxt;
  logic [QUEUE_BITS-1:0] q_r, q_nxt;
  logic [QCW-1:0]    qcnt_r, qcnt_nxt;
  logic              hdr_r, hdr_nxt;
  logic [NW-1:0]     cnt_r, cnt_nxt;
  logic [SW-1:0]     addr_r, addr_nxt;
  logic [SW-1:0]     s_r, s_nxt;
  logic [FB-1:0]     prev_r, prev_nxt;
  logic [FB-1:0]     fs_r, fs_nxt;
  logic [FB-1:0]     total_r, total_nxt;
  logic [DW-1:0]     cum_r, cum_nxt;
  logic [DW-1:0]     prod_r, prod_nxt;
  logic [VW-1:0]     range_r, range_nxt;
  logic              dstart_r, dstart_nxt;
  logic              ufl_r, ufl_nxt;
  logic [8:0]        sym_r, sym_nxt;
  logic              svalid_r, svalid_nxt;
  logic [1:0]        stat_r, stat_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_t              out_data_r, out_data_nxt;

  logic          div_done;
  logic [DW-1:0] div_q;
  logic [VW-1:0] div_dvs;
  logic          out_free;
  logic          srch_more;
  logic          ren_stop;
  logic          pull;
  logic          pb;
  logic [CB-1:0] sub;
  logic [VW-1:0] offs;

  asd_div #(
    .DW (DW),
    .VW (VW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (dstart_r),
    .dividend (prod_r),
    .divisor  (div_dvs),
    .done     (div_done),
    .quotient (div_q)
  );

  // The scaled count divides by the range, the bounds by the total.
  assign div_dvs = (state_r == S_DIV_CUM) ? range_r : VW'(total_r);

  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign offs      = {1'b0, CB'(code_r - low_r)} + VW'(1);
  assign pb        = (qcnt_r != '0) ? q_r[0] : 1'b0;
  assign srch_more = (32'(s_r) < NUM_SYMBOLS) && (DW'(rdata_r) > cum_r);

  // Renormalization case selection.
  always_comb begin
    ren_stop = 1'b0;
    sub      = '0;
    if (!high_r[CB-1]) begin
      sub = '0;
    end else if (low_r[CB-1]) begin
      sub = HALF;
    end else if (low_r >= QTR1 && high_r < QTR3) begin
      sub = QTR1;
    end else begin
      ren_stop = 1'b1;
    end
    if (cnt_r == NW'(CB)) begin
      ren_stop = 1'b1;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (cmd_valid) begin
          if (cmd.op == REQ_DECODE) begin
            state_nxt = hdr_r ? S_HDR : S_TOT_RD;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_HDR:      if (cnt_r == NW'(CB - 1)) state_nxt = S_TOT_RD;
      S_TOT_RD:   state_nxt = S_TOT_CHK;
      S_TOT_CHK:  state_nxt = (rdata_r == '0) ? S_DONE : S_MUL_CUM;
      S_MUL_CUM:  state_nxt = S_DIV_CUM;
      S_DIV_CUM:  if (div_done) state_nxt = S_SRCH_RD;
      S_SRCH_RD:  state_nxt = S_SRCH_CMP;
      S_SRCH_CMP: state_nxt = srch_more ? S_SRCH_RD : S_MUL_HI;
      S_MUL_HI:   state_nxt = S_DIV_HI;
      S_DIV_HI:   if (div_done) state_nxt = S_MUL_LO;
      S_MUL_LO:   state_nxt = S_DIV_LO;
      S_DIV_LO:   if (div_done) state_nxt = S_RENORM;
      S_RENORM:   if (ren_stop) state_nxt = S_DONE;
      S_DONE:     if (out_free) state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  // Datapath updates for each state.
  always_comb begin
    low_nxt       = low_r;
    high_nxt      = high_r;
    code_nxt      = code_r;
    q_nxt         = q_r;
    qcnt_nxt      = qcnt_r;
    hdr_nxt       = hdr_r;
    cnt_nxt       = cnt_r;
    addr_nxt      = addr_r;
    s_nxt         = s_r;
    prev_nxt      = prev_r;
    fs_nxt        = fs_r;
    total_nxt     = total_r;
    cum_nxt       = cum_r;
    prod_nxt      = prod_r;
    range_nxt     = range_r;
    dstart_nxt    = 1'b0;
    ufl_nxt       = ufl_r;
    sym_nxt       = sym_r;
    svalid_nxt    = svalid_r;
    stat_nxt      = stat_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    cmd_pop       = 1'b0;
    mem_we        = 1'b0;
    pull          = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (cmd_valid) begin
          cmd_pop    = 1'b1;
          sym_nxt    = '0;
          svalid_nxt = 1'b0;
          stat_nxt   = ST_OK;
          ufl_nxt    = 1'b0;
          case (cmd.op)
            REQ_LOAD: begin
              mem_we = cmd.idx_ok;
            end
            REQ_RESTART: begin
              low_nxt  = '0;
              high_nxt = '1;
              code_nxt = '0;
              q_nxt    = '0;
              qcnt_nxt = '0;
              hdr_nxt  = 1'b1;
            end
            REQ_APPEND: begin
              if ((32'(qcnt_r) + BYTE_BITS) > QUEUE_BITS) begin
                stat_nxt = ST_OVF;
              end else begin
                q_nxt    = q_r | (QUEUE_BITS'(cmd.data_byte) << qcnt_r);
                qcnt_nxt = QCW'(32'(qcnt_r) + BYTE_BITS);
              end
            end
            REQ_DECODE: begin
              addr_nxt = '0;
              cnt_nxt  = '0;
              if (hdr_r) begin
                code_nxt = '0;
              end
            end
            default: begin
              stat_nxt = ST_OK;
            end
          endcase
        end
      end
      // Fill the code value, most significant bit first.
      S_HDR: begin
        pull     = 1'b1;
        code_nxt = {code_r[CB-2:0], pb};
        cnt_nxt  = cnt_r + 1'b1;
        if (cnt_r == NW'(CB - 1)) begin
          hdr_nxt = 1'b0;
        end
      end
      S_TOT_CHK: begin
        total_nxt = rdata_r;
        prev_nxt  = rdata_r;
        addr_nxt  = SW'(1);
        s_nxt     = SW'(1);
        range_nxt = {1'b0, CB'(high_r - low_r)} + VW'(1);
        if (rdata_r == '0) begin
          stat_nxt = ufl_r ? ST_UFL : ST_OK;
        end
      end
      S_MUL_CUM: begin
        prod_nxt   = DW'(DW'(offs) * DW'(total_r)) - DW'(1);
        dstart_nxt = 1'b1;
      end
      S_DIV_CUM: begin
        if (div_done) begin
          cum_nxt = div_q;
        end
      end
      // Walk the descending table until an entry is not above the count.
      S_SRCH_CMP: begin
        if (srch_more) begin
          prev_nxt = rdata_r;
          s_nxt    = s_r + 1'b1;
          addr_nxt = s_r + 1'b1;
        end else begin
          fs_nxt = rdata_r;
        end
      end
      S_MUL_HI: begin
        prod_nxt   = DW'(DW'(range_r) * DW'(prev_r));
        dstart_nxt = 1'b1;
      end
      S_DIV_HI: begin
        if (div_done) begin
          high_nxt = low_r + div_q[CB-1:0] - CB'(1);
        end
      end
      S_MUL_LO: begin
        prod_nxt   = DW'(DW'(range_r) * DW'(fs_r));
        dstart_nxt = 1'b1;
      end
      S_DIV_LO: begin
        if (div_done) begin
          low_nxt = low_r + div_q[CB-1:0];
          cnt_nxt = '0;
        end
      end
      // One doubling of the interval per cycle.
      S_RENORM: begin
        if (ren_stop) begin
          sym_nxt    = 9'(s_r);
          svalid_nxt = 1'b1;
          stat_nxt   = ufl_r ? ST_UFL : ST_OK;
        end else begin
          pull     = 1'b1;
          low_nxt  = {CB'(low_r - sub)}  << 1;
          high_nxt = ({CB'(high_r - sub)} << 1) | CB'(1);
          code_nxt = {CB'(code_r - sub)} << 1 | CB'(pb);
          cnt_nxt  = cnt_r + 1'b1;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt             = 1'b1;
          out_data_nxt.symbol       = sym_r;
          out_data_nxt.symbol_valid = svalid_r;
          out_data_nxt.status       = stat_r;
          out_data_nxt.bits_queued  = 7'(qcnt_r);
        end
      end
      default: begin
        cmd_pop = 1'b0;
      end
    endcase
    // Take one bit from the queue, or flag an empty queue.
    if (pull) begin
      if (qcnt_r != '0) begin
        q_nxt    = q_r >> 1;
        qcnt_nxt = qcnt_r - 1'b1;
      end else begin
        ufl_nxt = 1'b1;
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      low_r       <= '0;
      high_r      <= '1;
      code_r      <= '0;
      q_r         <= '0;
      qcnt_r      <= '0;
      hdr_r       <= 1'b1;
      dstart_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      low_r       <= low_nxt;
      high_r      <= high_nxt;
      code_r      <= code_nxt;
      q_r         <= q_nxt;
      qcnt_r      <= qcnt_nxt;
      hdr_r       <= hdr_nxt;
      dstart_r    <= dstart_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Working registers.
  always_ff @(posedge clk) begin
    cnt_r      <= cnt_nxt;
    addr_r     <= addr_nxt;
    s_r        <= s_nxt;
    prev_r     <= prev_nxt;
    fs_r       <= fs_nxt;
    total_r    <= total_nxt;
    cum_r      <= cum_nxt;
    prod_r     <= prod_nxt;
    range_r    <= range_nxt;
    ufl_r      <= ufl_nxt;
    sym_r      <= sym_nxt;
    svalid_r   <= svalid_nxt;
    stat_r     <= stat_nxt;
    out_data_r <= out_data_nxt;
  end

  // Table memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[SW'(cmd.table_index)] <= cmd.table_value[FB-1:0];
    end
    rdata_r <= mem[addr_r];
  end

endmodule

// ===== hw/rtl/arithmetic_symbol_decoder.sv =====
// ----------------------------------------------------------------------------
// arithmetic_symbol_decoder
// Interval arithmetic decoder driven by a cumulative frequency table.
// ----------------------------------------------------------------------------
// Table loads, restarts and byte appends go from idle through the done state
// of the back end. A decode runs three divisions, a search that reads one
// table entry at a time, the renormalization doublings and, for the first
// decode after a restart, the fill of the code value. The serial divider,
// shared by the three divisions, and the single read port of the table
// memory set how long a decode runs. A two-entry queue in front and a result
// register behind let the next transaction be accepted and the last result
// wait while a decode is running.
module arithmetic_symbol_decoder #(
  parameter int CODE_BITS   = asd_pkg::CODE_BITS_DEF,
  parameter int NUM_SYMBOLS = asd_pkg::NUM_SYMBOLS_DEF,
  parameter int FREQ_BITS   = asd_pkg::FREQ_BITS_DEF,
  parameter int QUEUE_BITS  = asd_pkg::QUEUE_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  asd_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output asd_pkg::out_t out_data
);
  import asd_pkg::*;

  logic cmd_valid;
  logic cmd_pop;
  cmd_t cmd;

  asd_front #(
    .NUM_SYMBOLS (NUM_SYMBOLS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop),
    .cmd       (cmd)
  );

  asd_core #(
    .CODE_BITS   (CODE_BITS),
    .NUM_SYMBOLS (NUM_SYMBOLS),
    .FREQ_BITS   (FREQ_BITS),
    .QUEUE_BITS  (QUEUE_BITS)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop),
    .cmd       (cmd),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // A decoded symbol never comes with a dropped byte.
  a_sym_not_ovf: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.symbol_valid && out_data.status == ST_OVF))
    else $error("decoded symbol reported with overflow status");

  // Without a decoded symbol the symbol field reads zero.
  a_sym_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.symbol_valid || out_data.symbol == 9'd0))
    else $error("symbol field set without a decoded symbol");

  // The back end never pops an empty front-end queue.
  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop |-> cmd_valid)
    else $error("command popped from an empty queue");

endmodule
